// ----- hw/rtl/kha_pkg.sv -----
// Shared types, codes and helper functions for the key hold action engine.
`timescale 1ns / 1ps
`default_nettype none

package kha_pkg;

    localparam int ADDR_W      = 8;
    localparam int KEY_DEPTH   = 1 << ADDR_W;
    localparam int MAX_ACTIONS = 4;
    localparam int IDX_W       = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
    localparam int CNT_W       = $clog2(MAX_ACTIONS + 1);
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int NUM_MODS    = 8;

    // request modes
    localparam logic [1:0] MODE_KEY   = 2'd0;
    localparam logic [1:0] MODE_TIMER = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    // action kinds
    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_INJECT = 3'd1;
    localparam logic [2:0] ACT_TSTART = 3'd2;
    localparam logic [2:0] ACT_TSTOP  = 3'd3;
    localparam logic [2:0] ACT_SWITCH = 3'd4;

    // hold modes
    localparam logic [1:0] HM_SWITCH      = 2'd0;
    localparam logic [1:0] HM_TYPE_ERASE  = 2'd1;
    localparam logic [1:0] HM_SWITCH_TYPE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MODE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENGINE_EN    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_PRINT  = 8'd3;

    localparam logic [15:0] THRESHOLD_RST = 16'd400;

    localparam logic [7:0]  BKSP_CODE = 8'h08;
    localparam logic [15:0] BKSP_SCAN = 16'h000E;
    localparam logic [7:0]  SPACE_CODE = 8'h20;

    localparam logic [7:0] MOD_CODES [NUM_MODS] =
        '{8'h11, 8'h12, 8'h5B, 8'h5C, 8'hA2, 8'hA3, 8'hA4, 8'hA5};

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  key_code;
        logic [15:0] scan_code;
        logic        key_release;
        logic [7:0]  key_extra;
        logic        was_injected;
    } evt_t;

    typedef struct packed {
        logic [2:0]  action_kind;
        logic [7:0]  out_key_code;
        logic [15:0] out_scan_code;
        logic        out_release;
        logic [7:0]  out_extra;
        logic        also_type;
        logic [15:0] timer_ms;
        logic        suppress_event;
        logic        last_result;
    } res_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  code;
        logic [15:0] scan;
        logic        rel;
        logic [7:0]  extra;
        logic        also;
        logic [15:0] ms;
    } act_t;

    typedef act_t [MAX_ACTIONS-1:0] act_list_t;

    typedef struct packed {
        act_list_t        a;
        logic [CNT_W-1:0] n;
    } list_t;

    typedef struct packed {
        list_t lst;
        logic  sup;
    } batch_t;

    typedef struct packed {
        logic [1:0]  hold_mode;
        logic [15:0] hold_ms;
        logic        engine_enabled;
        logic        space_is_printable;
    } cfg_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              clr;
    } ram_ctl_t;

    typedef struct packed {
        logic [7:0]  code;
        logic [15:0] scan;
        logic [7:0]  extra;
    } held_t;

    function automatic list_t push(input list_t l, input act_t x);
        list_t r;
        r = l;
        if (r.n < CNT_W'(MAX_ACTIONS))
        begin
            r.a[r.n[IDX_W-1:0]] = x;
            r.n = r.n + 1'b1;
        end
        return r;
    endfunction

    function automatic act_t mk_key(input logic [2:0] kind, input logic [7:0] code,
                                    input logic [15:0] scan, input logic rel,
                                    input logic [7:0] extra, input logic also);
        act_t a;
        a       = '0;
        a.kind  = kind;
        a.code  = code;
        a.scan  = scan;
        a.rel   = rel;
        a.extra = extra;
        a.also  = also;
        return a;
    endfunction

    function automatic act_t mk_timer(input logic [2:0] kind, input logic [15:0] ms);
        act_t a;
        a      = '0;
        a.kind = kind;
        a.ms   = ms;
        return a;
    endfunction

    function automatic logic printable(input logic [7:0] vk, input logic space_ok);
        logic p;
        p = vk inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h60:8'h6F],
                       [8'hBA:8'hC0], [8'hDB:8'hDF], 8'hE2};
        if (vk == SPACE_CODE)
        begin
            p = space_ok;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/kha_ram.sv -----
// Per-key bitmap RAM: registered synchronous read, valid bits, bulk clear, write forwarding.
`timescale 1ns / 1ps
`default_nettype none

module kha_ram
    import kha_pkg::*;
#(
    parameter int DATA_W = 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ram_ctl_t          ctl,
    input  wire logic [DATA_W-1:0] wr_data,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0]    mem [KEY_DEPTH];
    logic [DATA_W-1:0]    mem_q_reg;
    logic [KEY_DEPTH-1:0] valid_reg;
    logic                 rd_valid_reg;
    logic                 fwd_hit_reg;
    logic                 fwd_clr_reg;
    logic [DATA_W-1:0]    fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            mem_q_reg    <= mem[ctl.rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            fwd_clr_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.clr)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[ctl.wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[ctl.rd_addr];
                // catch a write or clear landing in the same cycle as the read
                fwd_hit_reg  <= ctl.wr_en && (ctl.wr_addr == ctl.rd_addr);
                fwd_clr_reg  <= ctl.clr;
            end
        end
    end

    always_comb
    begin
        if (fwd_clr_reg)
            rd_data = '0;
        else if (fwd_hit_reg)
            rd_data = fwd_data_reg;
        else if (rd_valid_reg)
            rd_data = mem_q_reg;
        else
            rd_data = '0;
    end

    a_clr_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clr |-> !ctl.wr_en)
        else $error("bitmap clear and write in the same cycle");

endmodule

`default_nettype wire

// ----- hw/rtl/kha_event_unit.sv -----
// Decision stage: holds one request, reads the bitmaps, updates hold state, builds the action run.
`timescale 1ns / 1ps
`default_nettype none

module kha_event_unit
    import kha_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire logic     evt_valid,
    output logic          evt_ready,
    input  wire evt_t     evt,
    output ram_ctl_t      ctl_a,
    output logic [1:0]    a_wr_data,
    input  wire logic [1:0] a_rd_data,
    output ram_ctl_t      ctl_b,
    output logic [0:0]    b_wr_data,
    input  wire logic [0:0] b_rd_data,
    output logic          batch_valid,
    input  wire logic     batch_ready,
    output batch_t        batch
);

    logic                s1_valid_reg;
    evt_t                s1_reg;
    logic                hold_live_reg, hold_live_next;
    logic                hold_spent_reg, hold_spent_next;
    held_t               held_reg, held_next;
    logic [NUM_MODS-1:0] mod_reg, mod_next;

    logic              fire;
    logic              accept;
    logic              deferred;
    logic [7:0]        vk;
    logic              rel;
    logic              down_before;
    logic              ours;
    logic              swl;
    logic              do_eh;
    logic              start;
    logic              other;
    logic              rel_held;
    logic              inj_k;
    logic              fire_sw;
    logic              clr;
    logic              a_we;
    logic              b_we;
    logic [ADDR_W-1:0] b_addr;
    list_t             lst;
    logic              sup;

    assign fire        = s1_valid_reg && batch_ready;
    assign evt_ready   = !s1_valid_reg || batch_ready;
    assign accept      = evt_valid && evt_ready;
    assign batch_valid = s1_valid_reg;

    assign vk          = s1_reg.key_code;
    assign rel         = s1_reg.key_release;
    assign down_before = a_rd_data[1];
    assign ours        = a_rd_data[0];
    assign swl         = b_rd_data[0];
    assign deferred    = cfg.hold_mode != HM_TYPE_ERASE;

    always_comb
    begin
        hold_live_next  = hold_live_reg;
        hold_spent_next = hold_spent_reg;
        held_next       = held_reg;
        mod_next        = mod_reg;
        do_eh    = 1'b0;
        start    = 1'b0;
        other    = 1'b0;
        rel_held = 1'b0;
        inj_k    = 1'b0;
        fire_sw  = 1'b0;
        clr      = 1'b0;
        a_we     = 1'b0;
        b_we     = 1'b0;
        b_addr   = vk;
        b_wr_data = 1'b0;
        sup      = 1'b0;
        lst      = '0;

        case (s1_reg.mode)
            MODE_KEY:
            begin
                for (int i = 0; i < NUM_MODS; i++)
                begin
                    if (vk == MOD_CODES[i])
                    begin
                        mod_next[i] = !rel;
                    end
                end
                if (!s1_reg.was_injected)
                begin
                    a_we = 1'b1;
                    if (rel)
                    begin
                        if (swl)
                        begin
                            b_we = 1'b1;
                            sup  = 1'b1;
                        end
                        else if (hold_live_reg && (held_reg.code == vk))
                        begin
                            rel_held        = 1'b1;
                            sup             = deferred;
                            hold_live_next  = 1'b0;
                            hold_spent_next = 1'b0;
                        end
                        else if (cfg.engine_enabled)
                        begin
                            other = 1'b1;
                        end
                    end
                    else if (down_before)
                    begin
                        sup = ours;
                    end
                    else if (cfg.engine_enabled)
                    begin
                        if (printable(vk, cfg.space_is_printable) && !(|mod_next))
                        begin
                            start = 1'b1;
                            do_eh = hold_live_reg;
                        end
                        else
                        begin
                            other = 1'b1;
                        end
                    end
                    // an unrelated key interrupts the hold
                    if (other && hold_live_reg)
                    begin
                        if (!deferred)
                        begin
                            do_eh = !rel;
                        end
                        else
                        begin
                            do_eh = 1'b1;
                            if (!hold_spent_reg)
                            begin
                                inj_k = 1'b1;
                                sup   = 1'b1;
                            end
                        end
                    end
                end
            end
            MODE_TIMER:
            begin
                if (cfg.engine_enabled && hold_live_reg && !hold_spent_reg)
                begin
                    fire_sw         = 1'b1;
                    hold_spent_next = 1'b1;
                end
            end
            MODE_FLUSH:
            begin
                do_eh = hold_live_reg;
            end
            MODE_CLEAR:
            begin
                clr             = 1'b1;
                mod_next        = '0;
                hold_live_next  = 1'b0;
                hold_spent_next = 1'b0;
            end
            default:
            begin
                clr = 1'b0;
            end
        endcase

        if (do_eh)
        begin
            hold_live_next  = 1'b0;
            hold_spent_next = 1'b0;
            if (deferred)
            begin
                b_we      = 1'b1;
                b_addr    = held_reg.code;
                b_wr_data = 1'b1;
            end
        end
        if (start)
        begin
            hold_live_next  = 1'b1;
            hold_spent_next = 1'b0;
            held_next.code  = vk;
            held_next.scan  = s1_reg.scan_code;
            held_next.extra = s1_reg.key_extra;
            sup             = deferred;
        end

        a_wr_data = rel ? 2'b00 : {1'b1, ours | start};

        // action run, in emission order
        if (do_eh && !hold_spent_reg)
        begin
            lst = push(lst, mk_timer(ACT_TSTOP, 16'd0));
            if (deferred)
            begin
                lst = push(lst, mk_key(ACT_INJECT, held_reg.code, held_reg.scan, 1'b0,
                                       held_reg.extra, 1'b0));
                lst = push(lst, mk_key(ACT_INJECT, held_reg.code, held_reg.scan, 1'b1,
                                       held_reg.extra, 1'b0));
            end
        end
        if (start)
        begin
            lst = push(lst, mk_timer(ACT_TSTART, cfg.hold_ms));
        end
        if (rel_held && !hold_spent_reg)
        begin
            lst = push(lst, mk_timer(ACT_TSTOP, 16'd0));
            if (deferred)
            begin
                lst = push(lst, mk_key(ACT_INJECT, vk, s1_reg.scan_code, 1'b0,
                                       s1_reg.key_extra, 1'b0));
                lst = push(lst, mk_key(ACT_INJECT, vk, s1_reg.scan_code, 1'b1,
                                       s1_reg.key_extra, 1'b0));
            end
        end
        if (inj_k)
        begin
            lst = push(lst, mk_key(ACT_INJECT, vk, s1_reg.scan_code, rel,
                                   s1_reg.key_extra, 1'b0));
        end
        if (fire_sw)
        begin
            if (cfg.hold_mode == HM_TYPE_ERASE)
            begin
                lst = push(lst, mk_key(ACT_INJECT, BKSP_CODE, BKSP_SCAN, 1'b0, 8'd0, 1'b0));
                lst = push(lst, mk_key(ACT_INJECT, BKSP_CODE, BKSP_SCAN, 1'b1, 8'd0, 1'b0));
            end
            lst = push(lst, mk_key(ACT_SWITCH, held_reg.code, held_reg.scan, 1'b0,
                                   held_reg.extra, cfg.hold_mode == HM_SWITCH_TYPE));
        end
        // an empty run still reports once
        if (lst.n == '0)
        begin
            lst.n = CNT_W'(1);
        end
    end

    assign batch.lst = lst;
    assign batch.sup = sup;

    always_comb
    begin
        ctl_a.rd_en   = accept;
        ctl_a.rd_addr = evt.key_code;
        ctl_a.wr_en   = fire && a_we;
        ctl_a.wr_addr = vk;
        ctl_a.clr     = fire && clr;
        ctl_b.rd_en   = accept;
        ctl_b.rd_addr = evt.key_code;
        ctl_b.wr_en   = fire && b_we;
        ctl_b.wr_addr = b_addr;
        ctl_b.clr     = fire && clr;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= evt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            hold_live_reg  <= 1'b0;
            hold_spent_reg <= 1'b0;
            held_reg       <= '0;
            mod_reg        <= '0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (fire)
                s1_valid_reg <= 1'b0;
            if (fire)
            begin
                hold_live_reg  <= hold_live_next;
                hold_spent_reg <= hold_spent_next;
                held_reg       <= held_next;
                mod_reg        <= mod_next;
            end
        end
    end

    a_fired_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hold_spent_reg |-> hold_live_reg)
        else $error("hold marked fired without an active hold");

    a_clear_drops_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (s1_reg.mode == MODE_CLEAR)) |=> (!hold_live_reg && (mod_reg == '0)))
        else $error("clear request left hold or modifier state behind");

endmodule

`default_nettype wire

// ----- hw/rtl/kha_result_queue.sv -----
// Result queue: holds one action run and emits it one result per cycle while act_ready is high.
`timescale 1ns / 1ps
`default_nettype none

module kha_result_queue
    import kha_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   batch_valid,
    output logic        batch_ready,
    input  wire batch_t batch,
    output logic        act_valid,
    input  wire logic   act_ready,
    output res_t        act
);

    act_list_t        slot_reg;
    logic             sup_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             load;
    logic             pop;

    assign act_valid   = cnt_reg != '0;
    assign pop         = act_valid && act_ready;
    assign batch_ready = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && act_ready);
    assign load        = batch_valid && batch_ready;

    always_comb
    begin
        if (load)
            cnt_next = batch.lst.n;
        else if (pop)
            cnt_next = cnt_reg - 1'b1;
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= batch.lst.a;
            sup_reg  <= batch.sup;
        end
        else if (pop)
        begin
            // advance the run by one
            for (int i = 0; i < MAX_ACTIONS - 1; i++)
            begin
                slot_reg[i] <= slot_reg[i+1];
            end
        end
    end

    always_comb
    begin
        act.action_kind    = slot_reg[0].kind;
        act.out_key_code   = slot_reg[0].code;
        act.out_scan_code  = slot_reg[0].scan;
        act.out_release    = slot_reg[0].rel;
        act.out_extra      = slot_reg[0].extra;
        act.also_type      = slot_reg[0].also;
        act.timer_ms       = slot_reg[0].ms;
        act.suppress_event = sup_reg;
        act.last_result    = cnt_reg == CNT_W'(1);
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_ACTIONS))
        else $error("result count beyond run capacity");

    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (batch.lst.n != '0))
        else $error("empty action run loaded");

endmodule

`default_nettype wire

// ----- hw/rtl/key_hold_action_engine_core.sv -----
// Top level of the key hold action engine: configuration registers and block wiring.
`timescale 1ns / 1ps
`default_nettype none

// Each request yields a run of one to four results, emitted one per cycle while act_ready
// is high; a new request is taken while the previous run drains. The key bitmaps live
// in two 256-entry synchronous RAMs: a request reads them in the cycle it is taken, is
// decided and written back once the result queue can take its run, and its first
// result appears the cycle after that. Valid bits clear the bitmaps at once, at reset
// and on a clear request, so there is no start-up sweep. Write the configuration only
// while no request is in flight.
module key_hold_action_engine_core
    import kha_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  evt_valid,
    output logic                       evt_ready,
    input  wire evt_t                  evt,
    output logic                       act_valid,
    input  wire logic                  act_ready,
    output res_t                       act
);

    cfg_t       cfg_reg;
    ram_ctl_t   ctl_a;
    ram_ctl_t   ctl_b;
    logic [1:0] a_wr_data;
    logic [1:0] a_rd_data;
    logic [0:0] b_wr_data;
    logic [0:0] b_rd_data;
    logic       batch_valid;
    logic       batch_ready;
    batch_t     batch;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_mode          <= HM_SWITCH;
            cfg_reg.hold_ms            <= THRESHOLD_RST;
            cfg_reg.engine_enabled     <= 1'b1;
            cfg_reg.space_is_printable <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HOLD_MODE:   cfg_reg.hold_mode          <= cfg_data[1:0];
                CFG_THRESHOLD:   cfg_reg.hold_ms            <= cfg_data[15:0];
                CFG_ENGINE_EN:   cfg_reg.engine_enabled     <= cfg_data[0];
                CFG_SPACE_PRINT: cfg_reg.space_is_printable <= cfg_data[0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    kha_event_unit u_event (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .evt_valid   (evt_valid),
        .evt_ready   (evt_ready),
        .evt         (evt),
        .ctl_a       (ctl_a),
        .a_wr_data   (a_wr_data),
        .a_rd_data   (a_rd_data),
        .ctl_b       (ctl_b),
        .b_wr_data   (b_wr_data),
        .b_rd_data   (b_rd_data),
        .batch_valid (batch_valid),
        .batch_ready (batch_ready),
        .batch       (batch)
    );

    // key down and key ours
    kha_ram #(.DATA_W(2)) u_key_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_a),
        .wr_data (a_wr_data),
        .rd_data (a_rd_data)
    );

    // release to swallow
    kha_ram #(.DATA_W(1)) u_swallow_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_b),
        .wr_data (b_wr_data),
        .rd_data (b_rd_data)
    );

    kha_result_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .batch_valid (batch_valid),
        .batch_ready (batch_ready),
        .batch       (batch),
        .act_valid   (act_valid),
        .act_ready   (act_ready),
        .act         (act)
    );

endmodule

`default_nettype wire

// ----- sim/kha_check_pkg.sv -----
// Scoreboard for the key hold engine: predicts the action run of each request and checks it.
`timescale 1ns / 1ps

package kha_check_pkg;
    import kha_pkg::*;

    class action_scoreboard;
        res_t        expected_actions[$];
        int          errors;

        logic [1:0]  hold_mode;
        logic [15:0] hold_ms;
        logic        engine_en;
        logic        space_printable;

        bit          key_down[KEY_DEPTH];
        bit          mods_held[NUM_MODS];
        bit          key_ours[KEY_DEPTH];
        bit          swallow_rel[KEY_DEPTH];
        bit          hold_live;
        bit          hold_spent;
        logic [7:0]  held_code;
        logic [15:0] held_scan;
        logic [7:0]  held_extra;

        act_t        run[$];
        bit          run_suppress;

        function new();
            hold_mode       = HM_SWITCH;
            hold_ms         = THRESHOLD_RST;
            engine_en       = 1'b1;
            space_printable = 1'b0;
            held_code       = '0;
            held_scan       = '0;
            held_extra      = '0;
            errors          = 0;
            clear_state();
        endfunction

        // a clear request drops the hold and the key state; held key code, scan and extra survive
        function void clear_state();
            foreach (key_down[i])
            begin
                key_down[i]    = 1'b0;
                key_ours[i]    = 1'b0;
                swallow_rel[i] = 1'b0;
            end
            foreach (mods_held[i])
            begin
                mods_held[i] = 1'b0;
            end
            hold_live  = 1'b0;
            hold_spent = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_HOLD_MODE:   hold_mode       = data[1:0];
                CFG_THRESHOLD:   hold_ms         = data;
                CFG_ENGINE_EN:   engine_en       = data[0];
                CFG_SPACE_PRINT: space_printable = data[0];
                default:         ;
            endcase
        endfunction

        function void add_action(logic [2:0] kind, logic [7:0] code, logic [15:0] scan,
                                 logic rel, logic [7:0] extra, logic also, logic [15:0] ms);
            act_t a;
            a.kind  = kind;
            a.code  = code;
            a.scan  = scan;
            a.rel   = rel;
            a.extra = extra;
            a.also  = also;
            a.ms    = ms;
            // drop anything past the action limit
            if (run.size() < MAX_ACTIONS)
            begin
                run.push_back(a);
            end
        endfunction

        function void add_tap(logic [7:0] code, logic [15:0] scan, logic [7:0] extra);
            add_action(ACT_INJECT, code, scan, 1'b0, extra, 1'b0, 16'h0);
            add_action(ACT_INJECT, code, scan, 1'b1, extra, 1'b0, 16'h0);
        endfunction

        function bit replays_tap();
            return hold_mode != HM_TYPE_ERASE;
        endfunction

        function int modifier_slot(logic [7:0] vk);
            for (int i = 0; i < NUM_MODS; i++)
            begin
                if (MOD_CODES[i] == vk)
                begin
                    return i;
                end
            end
            return -1;
        endfunction

        function bit any_modifier();
            foreach (mods_held[i])
            begin
                if (mods_held[i])
                begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function bit starts_hold(logic [7:0] vk);
            if (vk == SPACE_CODE)
            begin
                return space_printable;
            end
            return (vk >= 8'h30 && vk <= 8'h39) || (vk >= 8'h41 && vk <= 8'h5A) ||
                   (vk >= 8'h60 && vk <= 8'h6F) || (vk >= 8'hBA && vk <= 8'hC0) ||
                   (vk >= 8'hDB && vk <= 8'hDF) || (vk == 8'hE2);
        endfunction

        function void end_hold();
            if (!hold_live)
            begin
                return;
            end
            if (!hold_spent)
            begin
                add_action(ACT_TSTOP, 8'h0, 16'h0, 1'b0, 8'h0, 1'b0, 16'h0);
                if (replays_tap())
                begin
                    add_tap(held_code, held_scan, held_extra);
                end
            end
            if (replays_tap())
            begin
                swallow_rel[held_code] = 1'b1;
            end
            hold_live  = 1'b0;
            hold_spent = 1'b0;
        endfunction

        // another key cuts in: deferred modes replay an unfired hold's tap, then re-inject it
        function void interrupt_hold(evt_t e);
            bit reorder;
            if (!hold_live)
            begin
                return;
            end
            if (!replays_tap())
            begin
                if (!e.key_release)
                begin
                    end_hold();
                end
                return;
            end
            reorder = !hold_spent;
            end_hold();
            if (reorder)
            begin
                add_action(ACT_INJECT, e.key_code, e.scan_code, e.key_release, e.key_extra,
                           1'b0, 16'h0);
                run_suppress = 1'b1;
            end
        endfunction

        function void key_event(evt_t e);
            int         slot;
            bit         down_before;
            logic [7:0] vk;
            vk   = e.key_code;
            slot = modifier_slot(vk);
            if (slot >= 0)
            begin
                mods_held[slot] = !e.key_release;
            end
            if (e.was_injected)
            begin
                return;
            end
            down_before  = key_down[vk];
            key_down[vk] = !e.key_release;

            if (e.key_release)
            begin
                if (swallow_rel[vk])
                begin
                    swallow_rel[vk] = 1'b0;
                    key_ours[vk]    = 1'b0;
                    run_suppress    = 1'b1;
                    return;
                end
                if (hold_live && held_code == vk)
                begin
                    key_ours[vk] = 1'b0;
                    if (!hold_spent)
                    begin
                        add_action(ACT_TSTOP, 8'h0, 16'h0, 1'b0, 8'h0, 1'b0, 16'h0);
                        // the replayed tap carries the release's own scan and extra
                        if (replays_tap())
                        begin
                            add_tap(vk, e.scan_code, e.key_extra);
                        end
                    end
                    run_suppress = replays_tap();
                    hold_live    = 1'b0;
                    hold_spent   = 1'b0;
                    return;
                end
                key_ours[vk] = 1'b0;
                if (engine_en)
                begin
                    interrupt_hold(e);
                end
                return;
            end

            // auto-repeat
            if (down_before)
            begin
                if (key_ours[vk])
                begin
                    run_suppress = 1'b1;
                end
                return;
            end
            if (!engine_en)
            begin
                return;
            end
            if (starts_hold(vk) && !any_modifier())
            begin
                end_hold();
                hold_live    = 1'b1;
                hold_spent   = 1'b0;
                held_code    = vk;
                held_scan    = e.scan_code;
                held_extra   = e.key_extra;
                key_ours[vk] = 1'b1;
                add_action(ACT_TSTART, 8'h0, 16'h0, 1'b0, 8'h0, 1'b0, hold_ms);
                run_suppress = replays_tap();
                return;
            end
            interrupt_hold(e);
        endfunction

        function void timer_expired();
            if (!engine_en || !hold_live || hold_spent)
            begin
                return;
            end
            hold_spent = 1'b1;
            if (hold_mode == HM_TYPE_ERASE)
            begin
                add_tap(BKSP_CODE, BKSP_SCAN, 8'h00);
            end
            add_action(ACT_SWITCH, held_code, held_scan, 1'b0, held_extra,
                       hold_mode == HM_SWITCH_TYPE, 16'h0);
        endfunction

        function void take_event(evt_t e);
            res_t r;
            act_t none_act;
            run.delete();
            run_suppress = 1'b0;
            case (e.mode)
                MODE_KEY:   key_event(e);
                MODE_TIMER: timer_expired();
                MODE_FLUSH: end_hold();
                default:    clear_state();
            endcase
            if (run.size() == 0)
            begin
                none_act = '0;
                run.push_back(none_act);
            end
            foreach (run[i])
            begin
                r.action_kind    = run[i].kind;
                r.out_key_code   = run[i].code;
                r.out_scan_code  = run[i].scan;
                r.out_release    = run[i].rel;
                r.out_extra      = run[i].extra;
                r.also_type      = run[i].also;
                r.timer_ms       = run[i].ms;
                r.suppress_event = run_suppress;
                r.last_result    = (i == run.size() - 1);
                expected_actions.push_back(r);
            end
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
            begin
                report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
            end
        endtask

        task check_action(res_t got);
            res_t want;
            if (expected_actions.size() == 0)
            begin
                report($sformatf("result of kind %0d with no request outstanding",
                                 got.action_kind));
                return;
            end
            want = expected_actions.pop_front();
            compare_field("action_kind", 32'(got.action_kind), 32'(want.action_kind));
            compare_field("out_key_code", 32'(got.out_key_code), 32'(want.out_key_code));
            compare_field("out_scan_code", 32'(got.out_scan_code), 32'(want.out_scan_code));
            compare_field("out_release", 32'(got.out_release), 32'(want.out_release));
            compare_field("out_extra", 32'(got.out_extra), 32'(want.out_extra));
            compare_field("also_type", 32'(got.also_type), 32'(want.also_type));
            compare_field("timer_ms", 32'(got.timer_ms), 32'(want.timer_ms));
            compare_field("suppress_event", 32'(got.suppress_event), 32'(want.suppress_event));
            compare_field("last_result", 32'(got.last_result), 32'(want.last_result));
        endtask
    endclass

endpackage

// ----- sim/key_hold_action_engine_core_tb.sv -----
// Testbench for the key hold action engine: directed and random key traffic, checked per action.
`timescale 1ns / 1ps

module key_hold_action_engine_core_tb;
    import kha_pkg::*;
    import kha_check_pkg::*;

    localparam logic [1:0] HM_UNUSED  = 2'd3;
    localparam int         IDLE_LIMIT = 2000;
    localparam logic [7:0] NEAR_PRINTABLE [12] =
        '{8'h00, 8'h1F, 8'h21, 8'h2F, 8'h3A, 8'h40, 8'h5F, 8'h70, 8'hB9, 8'hC1, 8'hDA, 8'hFF};

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  evt_valid;
    logic                  evt_ready;
    evt_t                  evt;
    logic                  act_valid;
    logic                  act_ready = 1'b0;
    res_t                  act;

    action_scoreboard sb;
    int               burst_left    = 0;
    int               requests_sent = 0;
    int               idle_cycles   = 0;
    int               rx_cycle      = 0;

    key_hold_action_engine_core u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .act_valid (act_valid),
        .act_ready (act_ready),
        .act       (act)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic evt_t mk_evt(logic [1:0] m, logic [7:0] code, logic [15:0] scan,
                                    logic rel, logic [7:0] extra, logic inj);
        evt_t e;
        e.mode         = m;
        e.key_code     = code;
        e.scan_code    = scan;
        e.key_release  = rel;
        e.key_extra    = extra;
        e.was_injected = inj;
        return e;
    endfunction

    function automatic logic [7:0] pick_printable();
        case ($urandom_range(0, 6))
            0:       return 8'($urandom_range(32'h30, 32'h39));
            1:       return 8'($urandom_range(32'h41, 32'h5A));
            2:       return 8'($urandom_range(32'h60, 32'h6F));
            3:       return 8'($urandom_range(32'hBA, 32'hC0));
            4:       return 8'($urandom_range(32'hDB, 32'hDF));
            5:       return 8'hE2;
            default: return SPACE_CODE;
        endcase
    endfunction

    function automatic logic [7:0] pick_other();
        case ($urandom_range(0, 3))
            0:       return MOD_CODES[$urandom_range(0, NUM_MODS - 1)];
            1:       return pick_printable();
            2:       return 8'($urandom);
            default: return NEAR_PRINTABLE[$urandom_range(0, 11)];
        endcase
    endfunction

    // hold valid across back-to-back requests; idle only between bursts
    task automatic send(input evt_t e);
        int gap;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                evt_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        evt       <= e;
        evt_valid <= 1'b1;
        do @(posedge clk); while (!evt_ready);
        sb.take_event(e);
        requests_sent++;
    endtask

    task automatic press_key(input logic [7:0] code);
        send(mk_evt(MODE_KEY, code, 16'($urandom), 1'b0, 8'($urandom), 1'b0));
    endtask

    task automatic release_key(input logic [7:0] code);
        send(mk_evt(MODE_KEY, code, 16'($urandom), 1'b1, 8'($urandom), 1'b0));
    endtask

    task automatic send_ctrl(input logic [1:0] m);
        send(mk_evt(m, 8'($urandom), 16'($urandom), 1'($urandom), 8'($urandom), 1'($urandom)));
    endtask

    task automatic send_noise();
        logic [63:0] r;
        r = {$urandom, $urandom};
        send(evt_t'(r[$bits(evt_t)-1:0]));
    endtask

    // drop valid, drain every outstanding result, then let the pipeline settle
    task automatic wait_idle();
        evt_valid <= 1'b0;
        while (sb.expected_actions.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(input logic [1:0] hm, input logic [15:0] thr,
                              input logic en, input logic sp);
        logic [CFG_DATA_W-1:0] d;
        wait_idle();
        d      = 16'($urandom);
        d[1:0] = hm;
        write_reg(CFG_HOLD_MODE, d);
        write_reg(CFG_THRESHOLD, thr);
        d      = 16'($urandom);
        d[0]   = en;
        write_reg(CFG_ENGINE_EN, d);
        d      = 16'($urandom);
        d[0]   = sp;
        write_reg(CFG_SPACE_PRINT, d);
        // no register behind this index
        write_reg(CFG_IDX_W'($urandom_range(32'(CFG_SPACE_PRINT) + 1, 255)), 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic hold_sequence();
        logic [7:0] k;
        logic [7:0] o;
        logic [7:0] m;
        k = pick_printable();
        o = pick_other();
        m = MOD_CODES[$urandom_range(0, NUM_MODS - 1)];
        case ($urandom_range(0, 8))
            0:
            begin
                press_key(k);
                send_ctrl(MODE_TIMER);
                release_key(k);
            end
            1:
            begin
                press_key(k);
                release_key(k);
            end
            2:
            begin
                press_key(k);
                press_key(o);
                if ($urandom_range(0, 1) == 1)
                begin
                    release_key(o);
                    release_key(k);
                end
                else
                begin
                    release_key(k);
                    release_key(o);
                end
            end
            3:
            begin
                press_key(k);
                send_ctrl(MODE_TIMER);
                send_ctrl(MODE_TIMER);
                press_key(o);
                release_key(k);
                release_key(o);
            end
            4:
            begin
                press_key(k);
                send_ctrl(MODE_FLUSH);
                release_key(k);
            end
            5:
            begin
                press_key(k);
                press_key(k);
                send_ctrl(MODE_TIMER);
                press_key(k);
                release_key(k);
            end
            6:
            begin
                press_key(m);
                press_key(k);
                release_key(k);
                release_key(m);
            end
            7:
            begin
                send(mk_evt(MODE_KEY, m, 16'($urandom), 1'b0, 8'($urandom), 1'b1));
                press_key(k);
                send_ctrl(MODE_TIMER);
                send(mk_evt(MODE_KEY, m, 16'($urandom), 1'b1, 8'($urandom), 1'b1));
                release_key(k);
            end
            default:
            begin
                press_key(k);
                send_ctrl(MODE_CLEAR);
                release_key(k);
            end
        endcase
    endtask

    task automatic random_phase(input int count);
        int stop_at;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                hold_sequence();
            end
            else
            begin
                send_noise();
            end
        end
    endtask

    task automatic directed_requests();
        send(mk_evt(MODE_KEY, 8'h41, 16'hFFFF, 1'b0, 8'hFF, 1'b0));
        press_key(8'h41);
        send_ctrl(MODE_TIMER);
        send_ctrl(MODE_TIMER);
        release_key(8'h41);
        send(mk_evt(MODE_KEY, 8'h42, 16'h0000, 1'b0, 8'h00, 1'b0));
        // a modifier cuts into the hold: stop, replay and re-inject
        press_key(8'h11);
        press_key(8'h43);
        release_key(8'h43);
        release_key(8'h11);
        release_key(8'h42);
        send(mk_evt(MODE_KEY, 8'hA2, 16'hFFFF, 1'b0, 8'hFF, 1'b1));
        press_key(8'h44);
        send(mk_evt(MODE_KEY, 8'hA2, 16'h0000, 1'b1, 8'h00, 1'b1));
        release_key(8'h44);
        send(mk_evt(MODE_KEY, 8'h00, 16'h0000, 1'b0, 8'h00, 1'b0));
        send(mk_evt(MODE_KEY, 8'hFF, 16'hFFFF, 1'b0, 8'hFF, 1'b0));
        release_key(8'hFF);
        release_key(8'h00);
        press_key(SPACE_CODE);
        release_key(SPACE_CODE);
        press_key(8'hE2);
        send_ctrl(MODE_FLUSH);
        release_key(8'hE2);
        press_key(8'h30);
        press_key(8'h39);
        send_ctrl(MODE_CLEAR);
        release_key(8'h39);
        release_key(8'h30);
    endtask

    initial
    begin
        sb = new();
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        evt_valid <= 1'b0;
        evt       <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        directed_requests();
        set_config(HM_TYPE_ERASE, 16'h0000, 1'b1, 1'b1);
        random_phase(22);
        set_config(HM_SWITCH_TYPE, 16'hFFFF, 1'b1, 1'b0);
        random_phase(22);
        set_config(HM_UNUSED, 16'($urandom), 1'b1, 1'b1);
        random_phase(22);
        set_config(HM_SWITCH, 16'($urandom), 1'b0, 1'b1);
        random_phase(22);
        set_config(HM_SWITCH, THRESHOLD_RST, 1'b1, 1'b0);
        random_phase(22);
        set_config(HM_TYPE_ERASE, 16'($urandom), 1'b1, 1'b0);
        random_phase(22);

        wait_idle();
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    // result side: check, then stall on its own schedule (steady, mostly ready, periodic, coin flip)
    always @(posedge clk)
    begin
        if (rst_n && act_valid && act_ready)
        begin
            sb.check_action(act);
        end
        rx_cycle++;
        case ((rx_cycle / 97) % 4)
            0:       act_ready <= 1'b1;
            1:       act_ready <= ($urandom_range(0, 3) != 0);
            2:       act_ready <= ((rx_cycle % 5) < 2);
            default: act_ready <= 1'($urandom_range(0, 1));
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (evt_valid && evt_ready) || (act_valid && act_ready) ||
            (cfg_valid && cfg_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
